/* hw/rtl/keypad_press_qualifier_top_assert.svh */
// Assertion macros for the keypad press qualifier
`ifndef KEYPAD_PRESS_QUALIFIER_TOP_ASSERT_SVH
`define KEYPAD_PRESS_QUALIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define KPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpq assertion failed");

`define KPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpq assertion failed");

`else

`define KPQ_ASSERT_SAME(label, ante, cons)

`define KPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/kpq_pkg.sv */
// Shared types, constants and key table for the keypad press qualifier
package kpq_pkg;

    localparam int KEY_W      = 4;
    localparam int TIME_W     = 16;
    localparam int ELAPSED_W  = 8;
    localparam int SCAN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int KEY_COUNT  = 12;

    localparam logic [KEY_W-1:0]  NO_KEY   = 4'd12;
    localparam logic [KEY_W-1:0]  KEY_MAX  = 4'd11;
    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

    localparam logic [TIME_W-1:0] CONFIRM_TIME_RST  = 16'd10;
    localparam logic [TIME_W-1:0] LOCKOUT_TIME_RST  = 16'd50;
    localparam logic [TIME_W-1:0] REARM_TIMEOUT_RST = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONFIRM_TIME  = 2'd0,
        CFG_LOCKOUT_TIME  = 2'd1,
        CFG_REARM_TIMEOUT = 2'd2
    } cfg_index_t;

    typedef logic [SCAN_W-1:0] key_code_table_t [KEY_COUNT];

    // raw matrix code per key: digits 0-9, then R, then P
    localparam key_code_table_t KEY_CODES = '{
        16'hDDFF, 16'hFDDF, 16'hFCFF, 16'hFDF7, 16'hFDFC, 16'hEDFF,
        16'hFDEF, 16'hFD3F, 16'hF5FF, 16'hFDFB, 16'hBDFF, 16'h7DFF
    };

endpackage

/* hw/rtl/kpq_decode.sv */
// Raw keypad matrix code to key value lookup
module kpq_decode
(
    input  logic [kpq_pkg::SCAN_W-1:0] raw_scan,
    output logic [kpq_pkg::KEY_W-1:0]  key
);

    always_comb
    begin
        key = kpq_pkg::NO_KEY;
        for (int k = 0; k < kpq_pkg::KEY_COUNT; k++)
        begin
            if (raw_scan == kpq_pkg::KEY_CODES[k])
            begin
                key = kpq_pkg::KEY_W'(k);
            end
        end
    end

endmodule

/* hw/rtl/keypad_press_qualifier_top.sv */
// Keypad press qualifier top level: debounce, report and lockout
//
// Takes one scan per clock unless stalled and updates the debounce state in
// the same cycle it is accepted. Scans that cause no report leave the output
// untouched. The output has a main register plus a one-entry skid: a reported
// key is registered in the main register, or in the skid when it is full, so
// input keeps flowing while one result waits; s_axis_tready drops only when
// both hold results. Configuration writes take effect on the next scan.
module keypad_press_qualifier_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] raw_scan, [23:16] elapsed_ms

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [3:0] key_code, [7:4] zero
);

    localparam int TW = kpq_pkg::TIME_W;
    localparam int KW = kpq_pkg::KEY_W;

    logic [TW-1:0] confirm_time_reg;
    logic [TW-1:0] lockout_time_reg;
    logic [TW-1:0] rearm_timeout_reg;

    logic          armed_reg,        armed_next;
    logic [KW-1:0] prev_key_reg,     prev_key_next;
    logic [TW-1:0] stable_time_reg,  stable_time_next;
    logic [TW-1:0] since_report_reg, since_report_next;

    logic          out_valid_reg,  out_valid_next;
    logic [KW-1:0] out_key_reg,    out_key_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [KW-1:0] skid_key_reg,   skid_key_next;

    logic [kpq_pkg::SCAN_W-1:0]    raw_scan;
    logic [kpq_pkg::ELAPSED_W-1:0] elapsed_ms;
    logic [KW-1:0]                 key;
    logic                          s_fire;
    logic                          m_fire;
    logic [TW:0]                   stable_sum;
    logic [TW:0]                   since_sum;
    logic [TW-1:0]                 stable_sat;
    logic [TW-1:0]                 since_sat;
    logic [TW-1:0]                 stable_upd;
    logic                          confirmed;
    logic                          report;

    assign raw_scan   = s_axis_tdata[15:0];
    assign elapsed_ms = s_axis_tdata[23:16];

    kpq_decode u_decode
    (
        .raw_scan (raw_scan),
        .key      (key)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_time_reg  <= kpq_pkg::CONFIRM_TIME_RST;
            lockout_time_reg  <= kpq_pkg::LOCKOUT_TIME_RST;
            rearm_timeout_reg <= kpq_pkg::REARM_TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (kpq_pkg::cfg_index_t'(cfg_index))
                kpq_pkg::CFG_CONFIRM_TIME:  confirm_time_reg  <= cfg_data;
                kpq_pkg::CFG_LOCKOUT_TIME:  lockout_time_reg  <= cfg_data;
                kpq_pkg::CFG_REARM_TIMEOUT: rearm_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;

    // debounce and qualification
    always_comb
    begin
        stable_sum = {1'b0, stable_time_reg} + {{(TW + 1 - kpq_pkg::ELAPSED_W){1'b0}}, elapsed_ms};
        since_sum  = {1'b0, since_report_reg} + {{(TW + 1 - kpq_pkg::ELAPSED_W){1'b0}}, elapsed_ms};
        stable_sat = stable_sum[TW] ? kpq_pkg::TIME_MAX : stable_sum[TW-1:0];
        since_sat  = since_sum[TW]  ? kpq_pkg::TIME_MAX : since_sum[TW-1:0];
        stable_upd = (key != prev_key_reg) ? '0 : stable_sat;
        confirmed  = stable_upd >= confirm_time_reg;
        report     = armed_reg && (key != kpq_pkg::NO_KEY) && confirmed;

        armed_next        = armed_reg;
        prev_key_next     = prev_key_reg;
        stable_time_next  = stable_time_reg;
        since_report_next = since_report_reg;

        if (s_fire)
        begin
            prev_key_next     = key;
            stable_time_next  = stable_upd;
            since_report_next = since_sat;
            if (report)
            begin
                armed_next        = 1'b0;
                since_report_next = '0;
            end
            else if (!armed_reg && (since_sat >= lockout_time_reg))
            begin
                if (((key == kpq_pkg::NO_KEY) && confirmed) || (since_sat >= rearm_timeout_reg))
                begin
                    armed_next = 1'b1;
                end
            end
        end
    end

    // output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        skid_valid_next = skid_valid_reg;
        skid_key_next   = skid_key_reg;

        if (m_fire)
        begin
            if (skid_valid_reg)
            begin
                out_key_next    = skid_key_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = s_fire && report;
                out_key_next   = key;
            end
        end
        else if (s_fire && report)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_key_next   = key;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_key_next   = key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b1;
            prev_key_reg     <= kpq_pkg::NO_KEY;
            stable_time_reg  <= '0;
            since_report_reg <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            armed_reg        <= armed_next;
            prev_key_reg     <= prev_key_next;
            stable_time_reg  <= stable_time_next;
            since_report_reg <= since_report_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg  <= out_key_next;
        skid_key_reg <= skid_key_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_key_reg};

`include "keypad_press_qualifier_top_assert.svh"

    `KPQ_ASSERT_NEXT(a_report_disarms, s_fire && report, !armed_reg && (since_report_reg == '0))
    `KPQ_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `KPQ_ASSERT_SAME(a_out_key_range, out_valid_reg, out_key_reg <= kpq_pkg::KEY_MAX)
    `KPQ_ASSERT_NEXT(a_report_visible, s_fire && report, out_valid_reg)

endmodule
